[sv/ttc_pkg.sv]
// Shared widths, types and constants of the triangle tangent block.
package ttc_pkg;

  // Coordinate format: signed fixed point with FRAC_W fraction bits
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;

  // Derived widths of the datapath
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W  = 2 * DELTA_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int MAG_W   = DIFF_W;
  localparam int SHF_W   = MAG_W + FRAC_W;
  localparam int HIGH_W  = SHF_W - COORD_W;
  localparam int CNT_W   = $clog2(COORD_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [MAG_W-1:0]   mag_t;

  // Corner codes
  typedef logic [1:0] corner_t;
  localparam corner_t CORNER_FIRST  = 2'd0;
  localparam corner_t CORNER_SECOND = 2'd1;
  localparam corner_t CORNER_LAST   = 2'd2;

  // Saturation limits of a coordinate
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Divider request and response
  typedef struct packed {
    logic  start;
    diff_t num;
    diff_t den;
  } div_req_t;

  typedef struct packed {
    logic   done;
    coord_t quot;
  } div_rsp_t;

endpackage

[sv/ttc_div.sv]
// Iterative signed divider: saturated (num * 2^FRAC_W) / den, one quotient bit a cycle.
module ttc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ttc_pkg::div_req_t req,
  output ttc_pkg::div_rsp_t rsp
);

  typedef enum logic [3:0] {
    DV_IDLE  = 4'b0001,
    DV_CHECK = 4'b0010,
    DV_RUN   = 4'b0100,
    DV_FIN   = 4'b1000
  } dv_state_t;

  dv_state_t                    state_r;
  ttc_pkg::mag_t                mn_r;
  ttc_pkg::mag_t                md_r;
  ttc_pkg::mag_t                rem_r;
  logic [ttc_pkg::COORD_W-1:0]  q_r;
  logic [ttc_pkg::CNT_W-1:0]    cnt_r;
  logic                         neg_r;
  logic                         ovf_r;
  logic                         done_r;
  ttc_pkg::coord_t              quot_r;

  logic [ttc_pkg::SHF_W-1:0]    shf;
  ttc_pkg::mag_t                high;
  logic [ttc_pkg::MAG_W:0]      trial;
  logic                         trial_ge;
  logic [ttc_pkg::MAG_W:0]      trial_sub;
  logic                         sat;
  ttc_pkg::coord_t              quot_nxt;

  // Scale the numerator and split off the part above the quotient bits
  always_comb begin
    shf  = {mn_r, {ttc_pkg::FRAC_W{1'b0}}};
    high = ttc_pkg::MAG_W'(shf[ttc_pkg::SHF_W-1:ttc_pkg::COORD_W]);
  end

  // One restoring step
  always_comb begin
    trial     = {rem_r, q_r[ttc_pkg::COORD_W-1]};
    trial_ge  = trial >= {1'b0, md_r};
    trial_sub = trial - {1'b0, md_r};
  end

  // Apply sign and saturate
  always_comb begin
    if (neg_r) begin
      sat      = ovf_r || (q_r > {1'b1, {(ttc_pkg::COORD_W-1){1'b0}}});
      quot_nxt = sat ? ttc_pkg::COORD_MIN : ttc_pkg::coord_t'(-q_r);
    end else begin
      sat      = ovf_r || q_r[ttc_pkg::COORD_W-1];
      quot_nxt = sat ? ttc_pkg::COORD_MAX : ttc_pkg::coord_t'(q_r);
    end
  end

  // Sequence the division
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DV_IDLE: begin
          if (req.start) begin
            neg_r   <= req.num[ttc_pkg::DIFF_W-1] ^ req.den[ttc_pkg::DIFF_W-1];
            mn_r    <= req.num[ttc_pkg::DIFF_W-1] ? ttc_pkg::mag_t'(-req.num)
                                                   : ttc_pkg::mag_t'(req.num);
            md_r    <= req.den[ttc_pkg::DIFF_W-1] ? ttc_pkg::mag_t'(-req.den)
                                                   : ttc_pkg::mag_t'(req.den);
            state_r <= DV_CHECK;
          end
        end
        DV_CHECK: begin
          ovf_r   <= high >= md_r;
          rem_r   <= high;
          q_r     <= shf[ttc_pkg::COORD_W-1:0];
          cnt_r   <= ttc_pkg::CNT_W'(ttc_pkg::COORD_W - 1);
          state_r <= (high >= md_r) ? DV_FIN : DV_RUN;
        end
        DV_RUN: begin
          rem_r <= trial_ge ? trial_sub[ttc_pkg::MAG_W-1:0] : trial[ttc_pkg::MAG_W-1:0];
          q_r   <= {q_r[ttc_pkg::COORD_W-2:0], trial_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= DV_FIN;
          end
        end
        DV_FIN: begin
          quot_r  <= quot_nxt;
          done_r  <= 1'b1;
          state_r <= DV_IDLE;
        end
        default: begin
          state_r <= DV_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  // Remainder stays below the divisor while iterating
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DV_RUN) |-> (rem_r < md_r))
    else $error("divider remainder not below divisor");

  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  // Done follows the final step only
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r == DV_FIN))
    else $error("divider done without final step");

endmodule

[sv/triangle_tangent_compute.sv]
// Top level: triangle corner store, shared multiplier, sequencer and result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | corner, pos_x/y/z, tex_u/v
//   out_    | output    | out_valid/out_stall| tangent_x/y/z, degenerate
//   cfg_    | input     | cfg_valid/cfg_ready| has_texcoords
//
// Corners 0 and 1 (and the unused code 3) are taken without stalling the input.
// After a last corner is taken the input stalls until the result is loaded: the
// shared multiplier runs MUL_A, MUL_B and DIFF per product pair, then per component
// the restoring divider yields one quotient bit a cycle, then the result state OUT.
// Without texture coordinates, or with a zero determinant, it goes on straight to OUT.
// Reset is synchronous, active low; it clears the stored corners to zero.
// A stalled result is held; the next result then waits with the input stalled.
module triangle_tangent_compute (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ttc_pkg::corner_t       in_corner,
  input  ttc_pkg::coord_t        in_pos_x,
  input  ttc_pkg::coord_t        in_pos_y,
  input  ttc_pkg::coord_t        in_pos_z,
  input  ttc_pkg::coord_t        in_tex_u,
  input  ttc_pkg::coord_t        in_tex_v,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ttc_pkg::coord_t        out_tangent_x,
  output ttc_pkg::coord_t        out_tangent_y,
  output ttc_pkg::coord_t        out_tangent_z,
  output logic                   out_degenerate,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_has_texcoords
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL_A = 6'b000010,
    S_MUL_B = 6'b000100,
    S_DIFF  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } ttc_state_t;

  localparam logic [1:0] PASS_DET  = 2'd0;
  localparam logic [1:0] PASS_LAST = 2'd3;

  ttc_state_t        state_r, state_nxt;
  logic [1:0]        pass_r;
  logic              has_tex_r;
  logic              out_valid_r;
  logic              zero_r;
  logic              deg_r;

  ttc_pkg::coord_t   first_pos_r  [3];
  ttc_pkg::coord_t   second_pos_r [3];
  ttc_pkg::coord_t   first_uv_r   [2];
  ttc_pkg::coord_t   second_uv_r  [2];
  ttc_pkg::coord_t   in_pos       [3];

  ttc_pkg::delta_t   d1u_r, d1v_r, d2u_r, d2v_r;
  ttc_pkg::delta_t   e1_r [3];
  ttc_pkg::delta_t   e2_r [3];
  ttc_pkg::coord_t   tan_r [3];

  ttc_pkg::delta_t   mul_a, mul_b;
  ttc_pkg::prod_t    prod_nxt;
  ttc_pkg::prod_t    prod_r, acc_r;
  ttc_pkg::diff_t    diff;
  ttc_pkg::diff_t    det_r;

  ttc_pkg::coord_t   out_x_r, out_y_r, out_z_r;
  logic              out_deg_r;

  ttc_pkg::div_req_t div_req;
  ttc_pkg::div_rsp_t div_rsp;

  logic              in_acc;
  logic              load_out;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Select operands of the shared multiplier
  always_comb begin
    if (pass_r == PASS_DET) begin
      mul_a = (state_r == S_MUL_B) ? d2u_r : d1u_r;
      mul_b = (state_r == S_MUL_B) ? d1v_r : d2v_r;
    end else begin
      mul_a = (state_r == S_MUL_B) ? d1v_r   : d2v_r;
      mul_b = (state_r == S_MUL_B) ? e2_r[0] : e1_r[0];
    end
  end

  assign prod_nxt = mul_a * mul_b;
  assign diff     = ttc_pkg::diff_t'(acc_r) - ttc_pkg::diff_t'(prod_r);

  // Start a division once a numerator is ready
  always_comb begin
    div_req.start = (state_r == S_DIFF) && (pass_r != PASS_DET);
    div_req.num   = diff;
    div_req.den   = det_r;
  end

  ttc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_corner == ttc_pkg::CORNER_LAST)) begin
          state_nxt = has_tex_r ? S_MUL_A : S_OUT;
        end
      end
      S_MUL_A: state_nxt = S_MUL_B;
      S_MUL_B: state_nxt = S_DIFF;
      S_DIFF: begin
        if (pass_r != PASS_DET) begin
          state_nxt = S_DIV;
        end else if (diff == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL_A;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (pass_r == PASS_LAST) ? S_OUT : S_MUL_A;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and stored corners
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_DET;
      has_tex_r   <= 1'b1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        first_pos_r[k]  <= '0;
        second_pos_r[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        first_uv_r[k]  <= '0;
        second_uv_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        has_tex_r <= cfg_has_texcoords;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && (in_corner == ttc_pkg::CORNER_FIRST)) begin
        for (int k = 0; k < 3; k++) begin
          first_pos_r[k] <= in_pos[k];
        end
        first_uv_r[0] <= in_tex_u;
        first_uv_r[1] <= in_tex_v;
      end
      if (in_acc && (in_corner == ttc_pkg::CORNER_SECOND)) begin
        for (int k = 0; k < 3; k++) begin
          second_pos_r[k] <= in_pos[k];
        end
        second_uv_r[0] <= in_tex_u;
        second_uv_r[1] <= in_tex_v;
      end
      if (in_acc && (in_corner == ttc_pkg::CORNER_LAST)) begin
        pass_r <= PASS_DET;
      end else if ((state_r == S_DIFF) && (pass_r == PASS_DET)) begin
        pass_r <= pass_r + 1'b1;
      end else if ((state_r == S_DIV) && div_rsp.done && (pass_r != PASS_LAST)) begin
        pass_r <= pass_r + 1'b1;
      end
    end
  end

  // Datapath: deltas, products, determinant and results
  always_ff @(posedge clk) begin
    if (in_acc && (in_corner == ttc_pkg::CORNER_LAST)) begin
      d1u_r  <= ttc_pkg::delta_t'(second_uv_r[0]) - ttc_pkg::delta_t'(first_uv_r[0]);
      d1v_r  <= ttc_pkg::delta_t'(second_uv_r[1]) - ttc_pkg::delta_t'(first_uv_r[1]);
      d2u_r  <= ttc_pkg::delta_t'(in_tex_u) - ttc_pkg::delta_t'(first_uv_r[0]);
      d2v_r  <= ttc_pkg::delta_t'(in_tex_v) - ttc_pkg::delta_t'(first_uv_r[1]);
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= ttc_pkg::delta_t'(second_pos_r[k]) - ttc_pkg::delta_t'(first_pos_r[k]);
        e2_r[k] <= ttc_pkg::delta_t'(in_pos[k]) - ttc_pkg::delta_t'(first_pos_r[k]);
      end
      zero_r <= !has_tex_r;
      deg_r  <= 1'b0;
    end
    if (state_r == S_MUL_A) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_MUL_B) begin
      acc_r  <= prod_r;
      prod_r <= prod_nxt;
    end
    if ((state_r == S_DIFF) && (pass_r == PASS_DET)) begin
      det_r <= diff;
      if (diff == '0) begin
        zero_r <= 1'b1;
        deg_r  <= 1'b1;
      end
    end
    // Advance to the next component: rotate edges, shift in the quotient
    if ((state_r == S_DIV) && div_rsp.done) begin
      e1_r[0]  <= e1_r[1];
      e1_r[1]  <= e1_r[2];
      e1_r[2]  <= e1_r[0];
      e2_r[0]  <= e2_r[1];
      e2_r[1]  <= e2_r[2];
      e2_r[2]  <= e2_r[0];
      tan_r[0] <= tan_r[1];
      tan_r[1] <= tan_r[2];
      tan_r[2] <= div_rsp.quot;
    end
    if (load_out) begin
      out_x_r   <= zero_r ? '0 : tan_r[0];
      out_y_r   <= zero_r ? '0 : tan_r[1];
      out_z_r   <= zero_r ? '0 : tan_r[2];
      out_deg_r <= deg_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tangent_x  = out_x_r;
  assign out_tangent_y  = out_y_r;
  assign out_tangent_z  = out_z_r;
  assign out_degenerate = out_deg_r;

  // A degenerate result carries a zero tangent
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_tangent_x == '0 && out_tangent_y == '0 && out_tangent_z == '0))
    else $error("degenerate result with nonzero tangent");

  // Divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  // The determinant pass never starts a division
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (pass_r != PASS_DET && state_r == S_DIFF))
    else $error("division started on the determinant pass");

  // A last corner starts the multiplier or goes straight to the result
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_corner == ttc_pkg::CORNER_LAST) |=>
      (state_r == S_MUL_A || state_r == S_OUT))
    else $error("last corner did not start the computation");

endmodule
